// ----- hdl/lqrc_pkg.sv -----
package lqrc_pkg;

   localparam int FRAC_BITS = 16;

   // register widths
   localparam int WEIGHT_W = 24;
   localparam int DT_W     = 17;
   localparam int TOL_W    = 23;
   localparam int LINLIM_W = 23;
   localparam int ANGLIM_W = 19;
   localparam int CFG_W    = 24;
   localparam int CFG_IDX_W = 3;

   // field widths
   localparam int POS_W  = 32;
   localparam int HEAD_W = 19;
   localparam int LIN_W  = 24;
   localparam int ANG_W  = 20;

   // datapath widths
   localparam int EP_W    = POS_W + 1;                   // position error
   localparam int EH_W    = HEAD_W + 1;                  // heading error
   localparam int MUL_W   = 34;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SUM_W   = 64;
   localparam int TOL2_W  = 2 * TOL_W;
   localparam int G_W     = WEIGHT_W + DT_W - FRAC_BITS;  // gain q*dt
   localparam int GDT_W   = G_W + DT_W;
   localparam int DEN_W   = WEIGHT_W + FRAC_BITS + 3;
   localparam int DMAG_W  = 33;
   localparam int NUMV_W  = G_W + DMAG_W;
   localparam int NUMW_W  = G_W + EH_W;
   localparam int QUO_W   = NUMV_W + FRAC_BITS;
   localparam int DACC_W  = 64;
   localparam int ANGQ_W  = 36;                          // Q30 angle
   localparam int CXY_W   = 34;                          // CORDIC x, y

   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W       = 5;
   localparam int DIV_STEPS    = QUO_W;
   localparam int CNT_W        = 7;

   localparam logic signed [ANGQ_W-1:0] PI_Q30        = 36'sd3373259426;
   localparam logic signed [ANGQ_W-1:0] TWO_PI_Q30    = 36'sd6746518852;
   localparam logic signed [ANGQ_W-1:0] PI_PLUS_HALF  = 36'sd5059889139;
   localparam logic signed [ANGQ_W-1:0] PI_MINUS_HALF = 36'sd1686629713;
   localparam logic signed [CXY_W-1:0]  CORDIC_GAIN   = 34'sd652032875;

   localparam int LIN_FIELD_MAX = (1 << (LIN_W - 1)) - 1;
   localparam int ANG_FIELD_MAX = (1 << (ANG_W - 1)) - 1;
   localparam int TWO_TENTHS    = ((2 << FRAC_BITS) + 5) / 10;
   localparam int THREE_TENTHS  = ((3 << FRAC_BITS) + 5) / 10;

   localparam logic [LIN_W-1:0] LIN_TWO_TENTHS =
      (TWO_TENTHS > LIN_FIELD_MAX) ? LIN_W'(LIN_FIELD_MAX) : LIN_W'(TWO_TENTHS);
   localparam logic [ANG_W-1:0] ANG_TWO_TENTHS =
      (TWO_TENTHS > ANG_FIELD_MAX) ? ANG_W'(ANG_FIELD_MAX) : ANG_W'(TWO_TENTHS);
   localparam logic [LIN_W-1:0] LIN_THREE_TENTHS =
      (THREE_TENTHS > LIN_FIELD_MAX) ? LIN_W'(LIN_FIELD_MAX) : LIN_W'(THREE_TENTHS);
   localparam logic [ANG_W-1:0] ANG_THREE_TENTHS =
      (THREE_TENTHS > ANG_FIELD_MAX) ? ANG_W'(ANG_FIELD_MAX) : ANG_W'(THREE_TENTHS);

   localparam logic [SUM_W-1:0] FAR_LIMIT = 64'd10000 << (2 * FRAC_BITS);

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_POS_WEIGHT,
      CFG_HEADING_WEIGHT,
      CFG_LIN_INPUT_WEIGHT,
      CFG_ANG_INPUT_WEIGHT,
      CFG_STEP_TIME,
      CFG_GOAL_TOLERANCE,
      CFG_MAX_LIN_VEL,
      CFG_MAX_ANG_VEL
   } cfg_index_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_EX2,
      MUL_EY2,
      MUL_EH2,
      MUL_TOL2,
      MUL_QPDT,
      MUL_QHDT,
      MUL_GPDT,
      MUL_GHDT,
      MUL_GHEH,
      MUL_CEX,
      MUL_SEY,
      MUL_GPDM
   } mul_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERR,
      S_FOLD,
      S_CORDIC,
      S_CEX,
      S_SEY,
      S_DWAIT,
      S_MAG,
      S_GPDM,
      S_NWAIT,
      S_DSTART,
      S_DIV,
      S_FIN,
      S_PUSH1,
      S_PUSH2
   } state_type;

   typedef struct packed {
      logic              load;
      logic              err;
      logic              fold;
      logic              cordic;
      logic [STEP_W-1:0] step;
      mul_op_type        mul_op;
      logic              mag;
      logic              div_start;
      logic              div_step;
      logic              fin;
      logic              push_cmd;
      logic              push_stop;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic reached;
   } status_type;

   function automatic logic [ANGQ_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
      logic [ANGQ_W-1:0] a;
      case (idx)
         5'd0:  a = 36'd843314857;
         5'd1:  a = 36'd497837829;
         5'd2:  a = 36'd263043837;
         5'd3:  a = 36'd133525159;
         5'd4:  a = 36'd67021687;
         5'd5:  a = 36'd33543516;
         5'd6:  a = 36'd16775851;
         5'd7:  a = 36'd8388437;
         5'd8:  a = 36'd4194283;
         5'd9:  a = 36'd2097149;
         5'd10: a = 36'd1048576;
         5'd11: a = 36'd524288;
         5'd12: a = 36'd262144;
         5'd13: a = 36'd131072;
         5'd14: a = 36'd65536;
         5'd15: a = 36'd32768;
         5'd16: a = 36'd16384;
         5'd17: a = 36'd8192;
         5'd18: a = 36'd4096;
         5'd19: a = 36'd2048;
         5'd20: a = 36'd1024;
         5'd21: a = 36'd512;
         5'd22: a = 36'd256;
         5'd23: a = 36'd128;
         5'd24: a = 36'd64;
         5'd25: a = 36'd32;
         5'd26: a = 36'd16;
         5'd27: a = 36'd8;
         5'd28: a = 36'd4;
         5'd29: a = 36'd2;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ----- hdl/lqrc_ctrl.sv -----
module lqrc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lqrc_pkg::status_type status,
   output lqrc_pkg::cmd_type    cmd
);

   lqrc_pkg::state_type state_ff, state_in;
   logic [lqrc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic goal_done_ff, goal_done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lqrc_pkg::S_IDLE;
         cnt_ff       <= '0;
         goal_done_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         goal_done_ff <= goal_done_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = '0;
      goal_done_in = goal_done_ff;
      case (state_ff)
         lqrc_pkg::S_IDLE: begin
            // drop the word once the goal is latched
            if (req_valid && !goal_done_ff) state_in = lqrc_pkg::S_ERR;
         end
         lqrc_pkg::S_ERR:  state_in = lqrc_pkg::S_FOLD;
         lqrc_pkg::S_FOLD: state_in = lqrc_pkg::S_CORDIC;
         lqrc_pkg::S_CORDIC: begin
            if (cnt_ff == lqrc_pkg::CNT_W'(lqrc_pkg::CORDIC_STEPS - 1))
               state_in = lqrc_pkg::S_CEX;
            else
               cnt_in = cnt_ff + 1'b1;
         end
         lqrc_pkg::S_CEX:    state_in = lqrc_pkg::S_SEY;
         lqrc_pkg::S_SEY:    state_in = lqrc_pkg::S_DWAIT;
         lqrc_pkg::S_DWAIT:  state_in = lqrc_pkg::S_MAG;
         lqrc_pkg::S_MAG:    state_in = lqrc_pkg::S_GPDM;
         lqrc_pkg::S_GPDM:   state_in = lqrc_pkg::S_NWAIT;
         lqrc_pkg::S_NWAIT:  state_in = lqrc_pkg::S_DSTART;
         lqrc_pkg::S_DSTART: state_in = lqrc_pkg::S_DIV;
         lqrc_pkg::S_DIV: begin
            if (cnt_ff == lqrc_pkg::CNT_W'(lqrc_pkg::DIV_STEPS - 1))
               state_in = lqrc_pkg::S_FIN;
            else
               cnt_in = cnt_ff + 1'b1;
         end
         lqrc_pkg::S_FIN: state_in = lqrc_pkg::S_PUSH1;
         lqrc_pkg::S_PUSH1: begin
            if (status.out_free)
               state_in = status.reached ? lqrc_pkg::S_PUSH2 : lqrc_pkg::S_IDLE;
         end
         lqrc_pkg::S_PUSH2: begin
            if (status.out_free) begin
               state_in     = lqrc_pkg::S_IDLE;
               goal_done_in = 1'b1;
            end
         end
         default: state_in = lqrc_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.mul_op = lqrc_pkg::MUL_NONE;
      cmd.step   = cnt_ff[lqrc_pkg::STEP_W-1:0];
      req_ready  = 1'b0;
      case (state_ff)
         lqrc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid && !goal_done_ff;
         end
         lqrc_pkg::S_ERR:  cmd.err  = 1'b1;
         lqrc_pkg::S_FOLD: cmd.fold = 1'b1;
         lqrc_pkg::S_CORDIC: begin
            cmd.cordic = 1'b1;
            // share the multiplier with the rotation; gains feed the later products
            case (cnt_ff)
               7'd0:    cmd.mul_op = lqrc_pkg::MUL_EX2;
               7'd1:    cmd.mul_op = lqrc_pkg::MUL_EY2;
               7'd2:    cmd.mul_op = lqrc_pkg::MUL_EH2;
               7'd3:    cmd.mul_op = lqrc_pkg::MUL_TOL2;
               7'd4:    cmd.mul_op = lqrc_pkg::MUL_QPDT;
               7'd5:    cmd.mul_op = lqrc_pkg::MUL_QHDT;
               7'd6:    cmd.mul_op = lqrc_pkg::MUL_GPDT;
               7'd7:    cmd.mul_op = lqrc_pkg::MUL_GHDT;
               7'd8:    cmd.mul_op = lqrc_pkg::MUL_GHEH;
               default: cmd.mul_op = lqrc_pkg::MUL_NONE;
            endcase
         end
         lqrc_pkg::S_CEX:    cmd.mul_op    = lqrc_pkg::MUL_CEX;
         lqrc_pkg::S_SEY:    cmd.mul_op    = lqrc_pkg::MUL_SEY;
         lqrc_pkg::S_MAG:    cmd.mag       = 1'b1;
         lqrc_pkg::S_GPDM:   cmd.mul_op    = lqrc_pkg::MUL_GPDM;
         lqrc_pkg::S_DSTART: cmd.div_start = 1'b1;
         lqrc_pkg::S_DIV:    cmd.div_step  = 1'b1;
         lqrc_pkg::S_FIN:    cmd.fin       = 1'b1;
         lqrc_pkg::S_PUSH1:  cmd.push_cmd  = status.out_free;
         lqrc_pkg::S_PUSH2:  cmd.push_stop = status.out_free;
         default: ;
      endcase
   end

endmodule

// ----- hdl/lqrc_div.sv -----
module lqrc_div (
   input  logic                          clock,
   input  logic                          start,
   input  logic                          step,
   input  logic [lqrc_pkg::QUO_W-1:0]    num,
   input  logic [lqrc_pkg::DEN_W-1:0]    den,
   output logic [lqrc_pkg::QUO_W-1:0]    quo
);

   // restoring division, one quotient bit per step; the numerator register
   // shifts out at the top and collects quotient bits at the bottom
   logic [lqrc_pkg::QUO_W-1:0] nq_ff;
   logic [lqrc_pkg::DEN_W-1:0] rem_ff;
   logic [lqrc_pkg::DEN_W-1:0] den_ff;
   logic [lqrc_pkg::DEN_W:0]   trial_in;
   logic                       fits_in;

   assign trial_in = {rem_ff, nq_ff[lqrc_pkg::QUO_W-1]};
   assign fits_in  = trial_in >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (start) begin
         nq_ff  <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (step) begin
         nq_ff  <= {nq_ff[lqrc_pkg::QUO_W-2:0], fits_in};
         rem_ff <= fits_in ? lqrc_pkg::DEN_W'(trial_in - {1'b0, den_ff})
                           : trial_in[lqrc_pkg::DEN_W-1:0];
      end
   end

   assign quo = nq_ff;

endmodule

// ----- hdl/lqrc_datapath.sv -----
module lqrc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [lqrc_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [lqrc_pkg::CFG_W-1:0]           csr_wdata,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_actual_x,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_actual_y,
   input  logic signed [lqrc_pkg::HEAD_W-1:0]   req_actual_heading,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_goal_x,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_goal_y,
   input  logic signed [lqrc_pkg::HEAD_W-1:0]   req_goal_heading,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lqrc_pkg::LIN_W-1:0]    rsp_lin_vel,
   output logic signed [lqrc_pkg::ANG_W-1:0]    rsp_ang_vel,
   output logic                                 rsp_goal_reached,
   output logic                                 rsp_last,
   input  lqrc_pkg::cmd_type                    cmd,
   output lqrc_pkg::status_type                 status
);

   localparam int F = lqrc_pkg::FRAC_BITS;

   // configuration
   logic [lqrc_pkg::WEIGHT_W-1:0] qp_ff, qh_ff, rl_ff, ra_ff;
   logic [lqrc_pkg::DT_W-1:0]     dt_ff;
   logic [lqrc_pkg::TOL_W-1:0]    tol_ff;
   logic [lqrc_pkg::LINLIM_W-1:0] vmax_ff;
   logic [lqrc_pkg::ANGLIM_W-1:0] wmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qp_ff   <= 24'd52429;
         qh_ff   <= 24'd52429;
         rl_ff   <= 24'd655;
         ra_ff   <= 24'd655;
         dt_ff   <= 17'd1966;
         tol_ff  <= 23'd328;
         vmax_ff <= 23'd327680;
         wmax_ff <= 19'd102944;
      end else if (csr_wr_en) begin
         case (lqrc_pkg::cfg_index_type'(csr_index))
            lqrc_pkg::CFG_POS_WEIGHT:       qp_ff   <= csr_wdata;
            lqrc_pkg::CFG_HEADING_WEIGHT:   qh_ff   <= csr_wdata;
            lqrc_pkg::CFG_LIN_INPUT_WEIGHT: rl_ff   <= csr_wdata;
            lqrc_pkg::CFG_ANG_INPUT_WEIGHT: ra_ff   <= csr_wdata;
            lqrc_pkg::CFG_STEP_TIME:        dt_ff   <= csr_wdata[lqrc_pkg::DT_W-1:0];
            lqrc_pkg::CFG_GOAL_TOLERANCE:   tol_ff  <= csr_wdata[lqrc_pkg::TOL_W-1:0];
            lqrc_pkg::CFG_MAX_LIN_VEL:      vmax_ff <= csr_wdata[lqrc_pkg::LINLIM_W-1:0];
            lqrc_pkg::CFG_MAX_ANG_VEL:      wmax_ff <= csr_wdata[lqrc_pkg::ANGLIM_W-1:0];
            default: ;
         endcase
      end
   end

   // pose error and magnitudes
   logic signed [lqrc_pkg::EP_W-1:0]   ex_ff, ey_ff;
   logic signed [lqrc_pkg::EH_W-1:0]   eh_ff;
   logic signed [lqrc_pkg::HEAD_W-1:0] hd_ff;
   logic [lqrc_pkg::EP_W-1:0]          aex_ff, aey_ff;
   logic [lqrc_pkg::EH_W-1:0]          aeh_ff;
   logic                               huge_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ex_ff <= $signed({req_actual_x[lqrc_pkg::POS_W-1], req_actual_x})
                - $signed({req_goal_x[lqrc_pkg::POS_W-1], req_goal_x});
         ey_ff <= $signed({req_actual_y[lqrc_pkg::POS_W-1], req_actual_y})
                - $signed({req_goal_y[lqrc_pkg::POS_W-1], req_goal_y});
         eh_ff <= $signed({req_actual_heading[lqrc_pkg::HEAD_W-1], req_actual_heading})
                - $signed({req_goal_heading[lqrc_pkg::HEAD_W-1], req_goal_heading});
         hd_ff <= req_actual_heading;
      end
      if (cmd.err) begin
         aex_ff <= ex_ff[lqrc_pkg::EP_W-1] ? lqrc_pkg::EP_W'(-ex_ff) : ex_ff;
         aey_ff <= ey_ff[lqrc_pkg::EP_W-1] ? lqrc_pkg::EP_W'(-ey_ff) : ey_ff;
         aeh_ff <= eh_ff[lqrc_pkg::EH_W-1] ? lqrc_pkg::EH_W'(-eh_ff) : eh_ff;
      end
   end

   assign huge_in = aex_ff[lqrc_pkg::EP_W-1] | aex_ff[lqrc_pkg::EP_W-2]
                  | aey_ff[lqrc_pkg::EP_W-1] | aey_ff[lqrc_pkg::EP_W-2];

   // heading reduction into [0, 2pi) offset by pi, then fold and rotate
   logic signed [lqrc_pkg::ANGQ_W-1:0] hq_in, wrap_in, wrap_ff;
   logic signed [lqrc_pkg::ANGQ_W-1:0] cr_ff, fold_in, atan_in;
   logic signed [lqrc_pkg::CXY_W-1:0]  cx_ff, cy_ff, shx_in, shy_in, c_in;
   logic                               flip_ff, flip_in;

   assign hq_in = (lqrc_pkg::ANGQ_W'(hd_ff) <<< (30 - F)) + lqrc_pkg::PI_Q30;

   always_comb begin
      if (hq_in >= lqrc_pkg::TWO_PI_Q30)
         wrap_in = hq_in - lqrc_pkg::TWO_PI_Q30;
      else if (hq_in < 0)
         wrap_in = hq_in + lqrc_pkg::TWO_PI_Q30;
      else
         wrap_in = hq_in;
   end

   always_comb begin
      flip_in = 1'b1;
      if (wrap_ff > lqrc_pkg::PI_PLUS_HALF)
         fold_in = lqrc_pkg::TWO_PI_Q30 - wrap_ff;
      else if (wrap_ff < lqrc_pkg::PI_MINUS_HALF)
         fold_in = -wrap_ff;
      else begin
         fold_in = wrap_ff - lqrc_pkg::PI_Q30;
         flip_in = 1'b0;
      end
   end

   assign shx_in  = cx_ff >>> cmd.step;
   assign shy_in  = cy_ff >>> cmd.step;
   assign atan_in = $signed(lqrc_pkg::atan_q30(cmd.step));
   assign c_in    = flip_ff ? -cx_ff : cx_ff;

   always_ff @(posedge clock) begin
      if (cmd.err) wrap_ff <= wrap_in;
      if (cmd.fold) begin
         cr_ff   <= fold_in;
         flip_ff <= flip_in;
         cx_ff   <= lqrc_pkg::CORDIC_GAIN;
         cy_ff   <= '0;
      end else if (cmd.cordic) begin
         if (!cr_ff[lqrc_pkg::ANGQ_W-1]) begin
            cx_ff <= cx_ff - shy_in;
            cy_ff <= cy_ff + shx_in;
            cr_ff <= cr_ff - atan_in;
         end else begin
            cx_ff <= cx_ff + shy_in;
            cy_ff <= cy_ff - shx_in;
            cr_ff <= cr_ff + atan_in;
         end
      end
   end

   // shared multiplier, one product per cycle, stored the cycle after
   logic signed [lqrc_pkg::MUL_W-1:0]  ma_in, mb_in;
   logic signed [lqrc_pkg::PROD_W-1:0] prod_ff;
   lqrc_pkg::mul_op_type               tag_ff;
   logic [lqrc_pkg::SUM_W-1:0]         sum_ff;
   logic [lqrc_pkg::TOL2_W-1:0]        tol2_ff;
   logic [lqrc_pkg::G_W-1:0]           gp_ff, gh_ff;
   logic [lqrc_pkg::DEN_W-1:0]         denv_ff, denw_ff;
   logic [lqrc_pkg::NUMV_W-1:0]        numv_ff;
   logic [lqrc_pkg::NUMW_W-1:0]        numw_ff;
   logic signed [lqrc_pkg::DACC_W-1:0] dacc_ff, dabs_in;
   logic [lqrc_pkg::DMAG_W-1:0]        dmag_ff;
   logic                               dneg_ff;

   always_comb begin
      ma_in = '0;
      mb_in = '0;
      case (cmd.mul_op)
         lqrc_pkg::MUL_EX2:  begin ma_in = $signed({1'b0, aex_ff}); mb_in = ma_in; end
         lqrc_pkg::MUL_EY2:  begin ma_in = $signed({1'b0, aey_ff}); mb_in = ma_in; end
         lqrc_pkg::MUL_EH2: begin
            ma_in = $signed(lqrc_pkg::MUL_W'(aeh_ff));
            mb_in = ma_in;
         end
         lqrc_pkg::MUL_TOL2: begin
            ma_in = $signed(lqrc_pkg::MUL_W'(tol_ff));
            mb_in = ma_in;
         end
         lqrc_pkg::MUL_QPDT: begin
            ma_in = $signed(lqrc_pkg::MUL_W'(qp_ff));
            mb_in = $signed(lqrc_pkg::MUL_W'(dt_ff));
         end
         lqrc_pkg::MUL_QHDT: begin
            ma_in = $signed(lqrc_pkg::MUL_W'(qh_ff));
            mb_in = $signed(lqrc_pkg::MUL_W'(dt_ff));
         end
         lqrc_pkg::MUL_GPDT: begin
            ma_in = $signed(lqrc_pkg::MUL_W'(gp_ff));
            mb_in = $signed(lqrc_pkg::MUL_W'(dt_ff));
         end
         lqrc_pkg::MUL_GHDT: begin
            ma_in = $signed(lqrc_pkg::MUL_W'(gh_ff));
            mb_in = $signed(lqrc_pkg::MUL_W'(dt_ff));
         end
         lqrc_pkg::MUL_GHEH: begin
            ma_in = $signed(lqrc_pkg::MUL_W'(gh_ff));
            mb_in = $signed(lqrc_pkg::MUL_W'(aeh_ff));
         end
         lqrc_pkg::MUL_CEX: begin
            ma_in = c_in;
            mb_in = lqrc_pkg::MUL_W'(ex_ff);
         end
         lqrc_pkg::MUL_SEY: begin
            ma_in = cy_ff;
            mb_in = lqrc_pkg::MUL_W'(ey_ff);
         end
         lqrc_pkg::MUL_GPDM: begin
            ma_in = $signed(lqrc_pkg::MUL_W'(gp_ff));
            mb_in = $signed(lqrc_pkg::MUL_W'(dmag_ff));
         end
         default: ;
      endcase
   end

   assign dabs_in = dacc_ff[lqrc_pkg::DACC_W-1] ? -dacc_ff : dacc_ff;

   always_ff @(posedge clock) begin
      if (reset)
         tag_ff <= lqrc_pkg::MUL_NONE;
      else
         tag_ff <= cmd.mul_op;
   end

   always_ff @(posedge clock) begin
      prod_ff <= ma_in * mb_in;
      case (tag_ff)
         lqrc_pkg::MUL_EX2:  sum_ff  <= prod_ff[lqrc_pkg::SUM_W-1:0];
         lqrc_pkg::MUL_EY2,
         lqrc_pkg::MUL_EH2:  sum_ff  <= sum_ff + prod_ff[lqrc_pkg::SUM_W-1:0];
         lqrc_pkg::MUL_TOL2: tol2_ff <= prod_ff[lqrc_pkg::TOL2_W-1:0];
         lqrc_pkg::MUL_QPDT: gp_ff   <= prod_ff[F+lqrc_pkg::G_W-1:F];
         lqrc_pkg::MUL_QHDT: gh_ff   <= prod_ff[F+lqrc_pkg::G_W-1:F];
         lqrc_pkg::MUL_GPDT:
            denv_ff <= lqrc_pkg::DEN_W'({rl_ff, F'(0)})
                     + lqrc_pkg::DEN_W'(prod_ff[lqrc_pkg::GDT_W-1:0]);
         lqrc_pkg::MUL_GHDT:
            denw_ff <= lqrc_pkg::DEN_W'({ra_ff, F'(0)})
                     + lqrc_pkg::DEN_W'(prod_ff[lqrc_pkg::GDT_W-1:0]);
         lqrc_pkg::MUL_GHEH: numw_ff <= prod_ff[lqrc_pkg::NUMW_W-1:0];
         lqrc_pkg::MUL_CEX:  dacc_ff <= prod_ff[lqrc_pkg::DACC_W-1:0];
         lqrc_pkg::MUL_SEY:  dacc_ff <= dacc_ff + prod_ff[lqrc_pkg::DACC_W-1:0];
         lqrc_pkg::MUL_GPDM: numv_ff <= prod_ff[lqrc_pkg::NUMV_W-1:0];
         default: ;
      endcase
      if (cmd.mag) begin
         // drop the 30 CORDIC fraction bits of the magnitude
         dmag_ff <= dabs_in[30+lqrc_pkg::DMAG_W-1:30];
         dneg_ff <= dacc_ff[lqrc_pkg::DACC_W-1];
      end
   end

   // two dividers run side by side
   logic [lqrc_pkg::QUO_W-1:0] quov_in, quow_in;

   lqrc_div u_div_lin (
      .clock (clock),
      .start (cmd.div_start),
      .step  (cmd.div_step),
      .num   ({numv_ff, F'(0)}),
      .den   (denv_ff),
      .quo   (quov_in)
   );

   lqrc_div u_div_ang (
      .clock (clock),
      .start (cmd.div_start),
      .step  (cmd.div_step),
      .num   (lqrc_pkg::QUO_W'({numw_ff, F'(0)})),
      .den   (denw_ff),
      .quo   (quow_in)
   );

   // final command
   logic [lqrc_pkg::LINLIM_W-1:0]    uv_in;
   logic [lqrc_pkg::ANGLIM_W-1:0]    uw_in;
   logic signed [lqrc_pkg::LIN_W-1:0] lin_in, lin_ff;
   logic signed [lqrc_pkg::ANG_W-1:0] ang_in, ang_ff;
   logic                             far_in, reached_in, reached_ff;

   assign uv_in = (quov_in > lqrc_pkg::QUO_W'(vmax_ff)) ? vmax_ff
                                                     : quov_in[lqrc_pkg::LINLIM_W-1:0];
   assign uw_in = (quow_in > lqrc_pkg::QUO_W'(wmax_ff)) ? wmax_ff
                                                     : quow_in[lqrc_pkg::ANGLIM_W-1:0];
   assign far_in     = huge_in || (sum_ff > lqrc_pkg::FAR_LIMIT);
   assign reached_in = !huge_in && (sum_ff < lqrc_pkg::SUM_W'(tol2_ff));

   always_comb begin
      if (far_in) begin
         lin_in = lqrc_pkg::LIN_THREE_TENTHS;
         ang_in = lqrc_pkg::ANG_THREE_TENTHS;
      end else begin
         if (denv_ff == '0)
            lin_in = lqrc_pkg::LIN_TWO_TENTHS;
         else if (dneg_ff)
            lin_in = lqrc_pkg::LIN_W'(uv_in);
         else
            lin_in = lqrc_pkg::LIN_W'(0) - lqrc_pkg::LIN_W'(uv_in);
         if (denw_ff == '0)
            ang_in = lqrc_pkg::ANG_TWO_TENTHS;
         else if (eh_ff[lqrc_pkg::EH_W-1])
            ang_in = lqrc_pkg::ANG_W'(uw_in);
         else
            ang_in = lqrc_pkg::ANG_W'(0) - lqrc_pkg::ANG_W'(uw_in);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         lin_ff     <= lin_in;
         ang_ff     <= ang_in;
         reached_ff <= reached_in;
      end
   end

   // output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.push_cmd || cmd.push_stop)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.push_cmd) begin
         rsp_lin_vel      <= lin_ff;
         rsp_ang_vel      <= ang_ff;
         rsp_goal_reached <= 1'b0;
         rsp_last         <= !reached_ff;
      end else if (cmd.push_stop) begin
         rsp_lin_vel      <= '0;
         rsp_ang_vel      <= '0;
         rsp_goal_reached <= 1'b1;
         rsp_last         <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.reached  = reached_ff;

endmodule

// ----- hdl/lqr_unicycle_pose_controller.sv -----
// LQR pose controller for a unicycle robot, one control tick per input word.
// Request channel (req_*): actual and goal pose, positions in Q16.16 and
// headings in Q3.16, valid/ready. Response channel (rsp_*): velocity command
// words, valid/ready. Each tick returns one word (lin_vel, ang_vel) with last
// set, or, when the pose error is inside the goal tolerance, that word with
// last clear followed by a stop word (zero velocities, goal_reached and last
// set). After the stop word the block latches done and drops every later tick without a response.
// Configuration (csr_*): write enable, register index, data; write only while
// no tick is in flight.
// Each tick runs 30 CORDIC steps, then the 74-step restoring dividers (one
// quotient bit per cycle, both channels in parallel), framed by control
// states. One tick is taken at a time: the next is accepted only after
// the response words of the last one are pushed to the output register.
// A finished response sits in an output register; the next tick is accepted
// while it waits. If the receiver stalls, the block holds the word and
// waits before loading the next one.
// Reset (synchronous, active high) restores the register defaults, clears
// the done latch and empties the output register.
module lqr_unicycle_pose_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [lqrc_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [lqrc_pkg::CFG_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_actual_x,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_actual_y,
   input  logic signed [lqrc_pkg::HEAD_W-1:0]   req_actual_heading,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_goal_x,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_goal_y,
   input  logic signed [lqrc_pkg::HEAD_W-1:0]   req_goal_heading,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lqrc_pkg::LIN_W-1:0]    rsp_lin_vel,
   output logic signed [lqrc_pkg::ANG_W-1:0]    rsp_ang_vel,
   output logic                                 rsp_goal_reached,
   output logic                                 rsp_last
);

   lqrc_pkg::cmd_type    cmd;
   lqrc_pkg::status_type status;

   lqrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lqrc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_actual_x       (req_actual_x),
      .req_actual_y       (req_actual_y),
      .req_actual_heading (req_actual_heading),
      .req_goal_x         (req_goal_x),
      .req_goal_y         (req_goal_y),
      .req_goal_heading   (req_goal_heading),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_lin_vel        (rsp_lin_vel),
      .rsp_ang_vel        (rsp_ang_vel),
      .rsp_goal_reached   (rsp_goal_reached),
      .rsp_last           (rsp_last),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

// ----- hdl/lqrc_checker.sv -----
module lqrc_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [lqrc_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [lqrc_pkg::CFG_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_actual_x,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_actual_y,
   input  logic signed [lqrc_pkg::HEAD_W-1:0]   req_actual_heading,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_goal_x,
   input  logic signed [lqrc_pkg::POS_W-1:0]    req_goal_y,
   input  logic signed [lqrc_pkg::HEAD_W-1:0]   req_goal_heading,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [lqrc_pkg::LIN_W-1:0]    rsp_lin_vel,
   input  logic signed [lqrc_pkg::ANG_W-1:0]    rsp_ang_vel,
   input  logic                                 rsp_goal_reached,
   input  logic                                 rsp_last
);

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lin_vel)
                                 && $stable(rsp_ang_vel) && $stable(rsp_last))
      else $error("response word dropped or changed while stalled");

   // the stop word carries zero velocities and closes the tick
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_goal_reached |-> rsp_lin_vel == '0 && rsp_ang_vel == '0
                                        && rsp_last)
      else $error("stop word malformed");

   // a word without last is followed by no other command word, only the stop word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !(rsp_valid && !rsp_goal_reached))
      else $error("stop word missing after a non-final word");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind lqr_unicycle_pose_controller lqrc_checker u_lqrc_checker (.*);
